[rtl/tcw_pkg.sv]
// tcw_pkg: shared types and constants for the text console writer.
// Request, response and internal command formats. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// widest cell index over the supported screen sizes (256 x 64 cells)
	localparam int CELL_IDX_W = 14;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] ATTR_RESET   = 8'h02;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_PUT,
		CMD_CLEAR,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  char_code;
		logic [10:0] cell_address;
	} req_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [10:0] cursor_position;
		logic        scrolled;
	} rsp_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic                  scroll;
		logic [CELL_IDX_W-1:0] cell_idx;
		logic [7:0]            char_code;
		logic [10:0]           cursor_position;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/tcw_front.sv]
// tcw_front: classifies requests into store commands and tracks the cursor.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic take,
	input  req_t      req,
	output cmd_t      cmd
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam logic [AW-1:0] LAST_ROW  = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);
	localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

	logic [AW-1:0] cursor_q, cursor_d;
	logic [CW-1:0] col_q, col_d;
	logic          is_newline;
	logic          in_range;

	assign is_newline = req.char_code == NEWLINE_CODE;
	assign in_range   = 32'(req.cell_address) < 32'(CELLS);

	always_comb begin
		cursor_d      = cursor_q;
		col_d         = col_q;
		cmd.kind      = CMD_NONE;
		cmd.scroll    = 1'b0;
		cmd.cell_idx  = CELL_IDX_W'(cursor_q);
		cmd.char_code = req.char_code;
		unique case (req.action)
			ACT_PUT: begin
				if (is_newline) begin
					if (cursor_q >= LAST_ROW) begin
						cmd.scroll = 1'b1;
						cursor_d   = LAST_ROW;
					end else begin
						cursor_d = cursor_q + COL_STEP - AW'(col_q);
					end
					col_d = '0;
				end else begin
					cmd.kind = CMD_PUT;
					if (cursor_q == LAST_CELL) begin
						cmd.scroll = 1'b1;
						cursor_d   = LAST_ROW;
						col_d      = '0;
					end else begin
						cursor_d = cursor_q + 1'b1;
						col_d    = (col_q == LAST_COL) ? '0 : col_q + 1'b1;
					end
				end
			end
			ACT_CLEAR: begin
				cmd.kind = CMD_CLEAR;
				cursor_d = '0;
				col_d    = '0;
			end
			ACT_READ: begin
				if (in_range) begin
					cmd.kind     = CMD_READ;
					cmd.cell_idx = CELL_IDX_W'(req.cell_address);
				end
			end
			default: ;
		endcase
		cmd.cursor_position = 11'(cursor_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
		end else if (take) begin
			cursor_q <= cursor_d;
			col_q    <= col_d;
		end
	end

endmodule

`default_nettype wire

[rtl/tcw_queue.sv]
// tcw_queue: two-entry command queue between front and back.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue import tcw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	output logic      space,
	input  wire logic pop,
	output logic      valid,
	output cmd_t      head
);

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign space   = count_q != 2'd2;
	assign valid   = count_q != 2'd0;
	assign head    = slot_q[rd_ptr_q];
	assign do_push = push && space;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

[rtl/tcw_back.sv]
// tcw_back: executes commands against the screen store (writes, reads,
// clear and scroll sweeps) and holds the response register. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] attr,
	input  wire logic       cmd_valid,
	input  cmd_t            cmd,
	output logic            cmd_pop,
	output logic            init_busy,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [AW-1:0] LAST_ROW  = AW'(CELLS - COLUMNS);
	localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
	localparam logic [AW-1:0] COL_STEP  = AW'(COLUMNS);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_READ,
		S_CLEAR,
		S_COPY,
		S_BLANK
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cnt_q;
	logic [AW-1:0] wr_idx_q;
	logic          pend_q;
	rsp_t          res_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [15:0]   mem [CELLS];
	logic [15:0]   rd_data_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [15:0]   mem_wd;
	logic          mem_re;
	logic [AW-1:0] mem_ra;
	logic          out_free;
	logic          cnt_last;
	logic [AW-1:0] cmd_idx;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid && out_free;
	assign init_busy = state_q == S_INIT;
	assign cnt_last  = cnt_q == LAST_CELL;
	assign cmd_idx   = cmd.cell_idx[AW-1:0];
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q;
		mem_wd = {attr, SPACE_CODE};
		mem_re = 1'b0;
		mem_ra = cmd_idx;
		unique case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				mem_wd = {ATTR_RESET, SPACE_CODE};
			end
			S_IDLE: begin
				if (cmd_pop) begin
					if (cmd.kind == CMD_PUT) begin
						mem_we = 1'b1;
						mem_wa = cmd_idx;
						mem_wd = {attr, cmd.char_code};
					end
					mem_re = cmd.kind == CMD_READ;
				end
			end
			S_CLEAR, S_BLANK: mem_we = 1'b1;
			S_COPY: begin
				mem_we = pend_q;
				mem_wa = wr_idx_q;
				mem_wd = rd_data_q;
				mem_re = cnt_q < LAST_ROW;
				mem_ra = cnt_q + COL_STEP;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rd_data_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_pop) begin
						res_q.cell_value      <= '0;
						res_q.cursor_position <= cmd.cursor_position;
						res_q.scrolled        <= cmd.scroll;
						cnt_q                 <= '0;
						pend_q                <= 1'b0;
						unique case (cmd.kind)
							CMD_CLEAR: state_q <= S_CLEAR;
							CMD_READ:  state_q <= S_READ;
							default: begin
								if (cmd.scroll) begin
									state_q <= S_COPY;
								end else begin
									rsp_valid_q           <= 1'b1;
									rsp_q.cell_value      <= '0;
									rsp_q.cursor_position <= cmd.cursor_position;
									rsp_q.scrolled        <= 1'b0;
								end
							end
						endcase
					end
				end
				S_READ: begin
					rsp_valid_q           <= 1'b1;
					rsp_q.cell_value      <= rd_data_q;
					rsp_q.cursor_position <= res_q.cursor_position;
					rsp_q.scrolled        <= res_q.scrolled;
					state_q               <= S_IDLE;
				end
				S_COPY: begin
					if (cnt_q < LAST_ROW) begin
						pend_q   <= 1'b1;
						wr_idx_q <= cnt_q;
						cnt_q    <= cnt_q + 1'b1;
					end else begin
						pend_q  <= 1'b0;
						state_q <= S_BLANK;
					end
				end
				S_CLEAR, S_BLANK: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						rsp_valid_q <= 1'b1;
						rsp_q       <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/text_console_writer.sv]
// Text console writer: the front end takes one request per cycle into a two-entry
// command queue while there is room; the back end executes commands on a single
// write port, single read port screen store of COLUMNS*ROWS cells. Clears and scrolls
// sweep the store at one store write per cycle; a scroll copies the rows up, then
// blanks the last row. After reset the store is blanked with req_ready low;
// cfg_data is taken at any time.
// Depends on tcw_pkg, tcw_front, tcw_queue, tcw_back.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  req_t            req_data,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data
);

	logic [7:0] attr_q;
	logic       take;
	cmd_t       front_cmd;
	cmd_t       head_cmd;
	logic       q_space;
	logic       q_valid;
	logic       q_pop;
	logic       init_busy;

	assign cfg_ready = 1'b1;
	assign req_ready = q_space && !init_busy;
	assign take      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			attr_q <= ATTR_RESET;
		else if (cfg_valid && cfg_ready)
			attr_q <= cfg_data;
	end

	tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.req    (req_data),
		.cmd    (front_cmd)
	);

	tcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.push_cmd (front_cmd),
		.space    (q_space),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (head_cmd)
	);

	tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.attr      (attr_q),
		.cmd_valid (q_valid),
		.cmd       (head_cmd),
		.cmd_pop   (q_pop),
		.init_busy (init_busy),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

`default_nettype wire

[rtl/tcw_checker.sv]
// tcw_checker: port-level assertions for text_console_writer, bound to the top.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker import tcw_pkg::*; #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input rsp_t      rsp_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam logic [10:0] LAST_ROW_POS = 11'(CELLS - COLUMNS);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response changed while stalled");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (CELLS > 2048) || (32'(rsp_data.cursor_position) < 32'(CELLS)))
		else $error("cursor beyond screen");

	a_scroll: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.scrolled |->
			rsp_data.cursor_position == LAST_ROW_POS && rsp_data.cell_value == 16'd0)
		else $error("scroll left cursor off last row start");

endmodule

bind text_console_writer tcw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcw_checker (.*);

`default_nettype wire

[verif/text_console_writer_tb.sv]
// Self-checking bench for text_console_writer: a screen and cursor predictor scores every
// response, while randomly paced request and response channels exercise scrolls and clears.
// Depends on tcw_pkg and the text_console_writer RTL.
`timescale 1ns / 1ps

module text_console_writer_tb;
	import tcw_pkg::*;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int SETTLE_CYCLES = 2 * CELLS + 20;
	localparam longint CYCLE_LIMIT = 6000000;
	localparam int PHASE_ITEMS = 130;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [7:0] cfg_data;

	int idle_pct = 28;
	int hold_cycles = 0;
	longint cycles = 0;

	class console_checker;
		logic [15:0] screen [CELLS];
		int unsigned cursor;
		logic [7:0] attribute;
		rsp_t expected_rsp [$];
		int errors;

		function new();
			attribute = ATTR_RESET;
			errors = 0;
			blank_screen(0, CELLS);
			cursor = 0;
		endfunction

		function void blank_screen(int unsigned first, int unsigned last);
			for (int unsigned i = first; i < last; i++)
				screen[i] = {attribute, SPACE_CODE};
		endfunction

		function void set_attribute(logic [7:0] value);
			attribute = value;
		endfunction

		function int outstanding();
			return expected_rsp.size();
		endfunction

		// advance the screen for one accepted request and queue its response
		function void apply_request(req_t r);
			rsp_t want;
			want = '0;
			case (r.action)
			ACT_PUT: begin
				if (r.char_code == NEWLINE_CODE) begin
					cursor = cursor + COLUMNS - (cursor % COLUMNS);
				end else begin
					screen[cursor] = {attribute, r.char_code};
					cursor++;
				end
				if (cursor >= CELLS) begin
					for (int unsigned i = 0; i < CELLS - COLUMNS; i++)
						screen[i] = screen[i + COLUMNS];
					blank_screen(CELLS - COLUMNS, CELLS);
					cursor = CELLS - COLUMNS;
					want.scrolled = 1'b1;
				end
			end
			ACT_CLEAR: begin
				blank_screen(0, CELLS);
				cursor = 0;
			end
			ACT_READ: begin
				if (r.cell_address < CELLS)
					want.cell_value = screen[r.cell_address];
			end
			default: ;
			endcase
			want.cursor_position = cursor[10:0];
			expected_rsp.push_back(want);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				$display("%0t: response with none outstanding: %h", $time, got);
				errors++;
				return;
			end
			want = expected_rsp.pop_front();
			if (got.cell_value !== want.cell_value) begin
				$display("%0t: cell_value expected %h actual %h", $time,
					want.cell_value, got.cell_value);
				errors++;
			end
			if (got.cursor_position !== want.cursor_position) begin
				$display("%0t: cursor_position expected %0d actual %0d", $time,
					want.cursor_position, got.cursor_position);
				errors++;
			end
			if (got.scrolled !== want.scrolled) begin
				$display("%0t: scrolled expected %b actual %b", $time,
					want.scrolled, got.scrolled);
				errors++;
			end
		endfunction
	endclass

	console_checker board;

	text_console_writer #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// response side: random back-pressure plus requested hold-offs
	initial begin
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				hold_cycles--;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			board.check_response(rsp_data);
	end

	function automatic req_t make_request(logic [1:0] action, logic [7:0] char_code,
			logic [10:0] cell_address);
		req_t r;
		r.action = action;
		r.char_code = char_code;
		r.cell_address = cell_address;
		return r;
	endfunction

	// mostly text lines with newlines, some reads, rare clears and unused actions
	function automatic req_t random_request();
		req_t r;
		int unsigned pick;
		r = make_request(ACT_PUT, 8'($urandom_range(0, 255)),
			11'($urandom_range(0, CELLS - 1)));
		pick = $urandom_range(0, 199);
		if (pick >= 130 && pick < 164) begin
			r.char_code = NEWLINE_CODE;
		end else if (pick >= 164 && pick < 194) begin
			r.action = ACT_READ;
			if ($urandom_range(0, 3) == 0)
				r.cell_address = 11'($urandom_range(0, 2047));
		end else if (pick == 194) begin
			r.action = ACT_CLEAR;
		end else if (pick > 194) begin
			r.action = ACT_UNUSED;
		end
		return r;
	endfunction

	task automatic send_request(input req_t r);
		while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do
			@(posedge clk);
		while (!req_ready);
		board.apply_request(r);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0)
			@(posedge clk);
	endtask

	// attribute only changes once the engine has finished any scroll or clear
	task automatic write_attribute(input logic [7:0] value);
		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_attribute(value);
	endtask

	initial begin
		req_t r;
		int counted;
		logic [7:0] attr;
		board = new();
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= ATTR_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset contents, read bounds, character extremes, newline, unused action
		send_request(make_request(ACT_READ, 8'h00, 11'd0));
		send_request(make_request(ACT_READ, 8'hFF, 11'(CELLS - 1)));
		send_request(make_request(ACT_READ, 8'h00, 11'(CELLS)));
		send_request(make_request(ACT_READ, 8'h00, 11'h7FF));
		send_request(make_request(ACT_PUT, 8'h41, 11'h000));
		send_request(make_request(ACT_PUT, 8'h00, 11'h7FF));
		send_request(make_request(ACT_PUT, 8'hFF, 11'h000));
		send_request(make_request(ACT_PUT, NEWLINE_CODE, 11'h000));
		send_request(make_request(ACT_PUT, NEWLINE_CODE, 11'h555));
		send_request(make_request(ACT_UNUSED, 8'hFF, 11'h7FF));
		send_request(make_request(ACT_READ, 8'h00, 11'd0));
		send_request(make_request(ACT_READ, 8'h00, 11'd1));
		send_request(make_request(ACT_READ, 8'h00, 11'd2));
		write_attribute(8'hFF);
		send_request(make_request(ACT_PUT, 8'h55, 11'h2AA));
		send_request(make_request(ACT_PUT, 8'hAA, 11'h555));
		send_request(make_request(ACT_CLEAR, 8'h0A, 11'h7FF));
		send_request(make_request(ACT_READ, 8'h00, 11'd0));
		send_request(make_request(ACT_READ, 8'h00, 11'd3));
		write_attribute(8'h00);
		send_request(make_request(ACT_PUT, 8'h7F, 11'h000));
		send_request(make_request(ACT_READ, 8'h00, 11'd0));
		send_request(make_request(ACT_PUT, NEWLINE_CODE, 11'h000));
		send_request(make_request(ACT_READ, 8'h00, 11'd1));

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
			0: attr = 8'h07;
			2: attr = 8'h80;
			4: attr = 8'hFF;
			default: attr = 8'($urandom_range(0, 255));
			endcase
			write_attribute(attr);
			idle_pct = (phase == 1) ? 0 : 28;
			if (phase == 2)
				hold_cycles = 400;
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				r = random_request();
				send_request(r);
				if (r.action != ACT_UNUSED)
					counted++;
				if (phase == 3 && counted == PHASE_ITEMS / 2 && r.action != ACT_UNUSED)
					drain_responses();
			end
		end

		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
